// File: rtl/upi_pkg.sv
`default_nettype none

package upi_pkg;

    // Field widths
    localparam int NOISE_W     = 16;
    localparam int ST_W        = 16;
    localparam int SPEED_W     = 24;
    localparam int TURN_W      = 32;
    localparam int SNS_W       = 23;
    localparam int TNS_W       = 31;
    localparam int OUT_POS_W   = 32;
    localparam int HEAD_W      = 16;
    localparam int ANG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Register reset values
    localparam logic [ST_W-1:0]           STEP_TIME_RST  = 16'd3277;
    localparam logic signed [SPEED_W-1:0] SPEED_RST      = 24'sd65536;
    localparam logic signed [TURN_W-1:0]  TURN_RATE_RST  = 32'sd68356528;
    localparam logic [SNS_W-1:0]          SNS_RST        = 23'd65536;
    localparam logic [TNS_W-1:0]          TNS_RST        = 31'd20822560;

    // CORDIC
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_FRAC  = 30;
    localparam int ITER_W       = 5;
    localparam logic [CORDIC_FRAC-1:0] CORDIC_GAIN_INV = 30'd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_TIME  = 3'd0,
        REG_SPEED      = 3'd1,
        REG_TURN_RATE  = 3'd2,
        REG_SPEED_NSC  = 3'd3,
        REG_TURN_NSC   = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        POSE_TRUE  = 1'b0,
        POSE_NOISY = 1'b1
    } pose_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SN,
        MUL_TN,
        MUL_V,
        MUL_W,
        MUL_C,
        MUL_S
    } mul_op_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_VN,
        WB_WN,
        WB_D,
        WB_ANG,
        WB_X,
        WB_Y
    } wb_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NS,
        ST_NT,
        ST_NW,
        ST_CLOAD,
        ST_CROT,
        ST_CFIN,
        ST_MD,
        ST_MX,
        ST_MY,
        ST_MEND,
        ST_OUT
    } fsm_state_t;

    typedef struct packed {
        mul_op_t mul;
        wb_op_t  wb;
        pose_t   pose;
        logic    in_load;
        logic    cordic_load;
        logic    cordic_run;
        logic    cordic_fin;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cordic_last;
    } ctrl_status_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [CORDIC_FRAC-1:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic [CORDIC_FRAC-1:0] r;
        unique case (idx)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/upi_cfg.sv
`default_nettype none

module upi_cfg import upi_pkg::*; (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_wdata,
    output logic [ST_W-1:0]                   step_time,
    output logic signed [SPEED_W-1:0]         speed,
    output logic signed [TURN_W-1:0]          turn_rate,
    output logic [SNS_W-1:0]                  speed_noise_scale,
    output logic [TNS_W-1:0]                  turn_noise_scale
);

    logic [ST_W-1:0]          step_time_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [TURN_W-1:0] turn_rate_reg;
    logic [SNS_W-1:0]         sns_reg;
    logic [TNS_W-1:0]         tns_reg;

    // Unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg <= STEP_TIME_RST;
            speed_reg     <= SPEED_RST;
            turn_rate_reg <= TURN_RATE_RST;
            sns_reg       <= SNS_RST;
            tns_reg       <= TNS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STEP_TIME: step_time_reg <= cfg_wdata[ST_W-1:0];
                REG_SPEED:     speed_reg     <= $signed(cfg_wdata[SPEED_W-1:0]);
                REG_TURN_RATE: turn_rate_reg <= $signed(cfg_wdata[TURN_W-1:0]);
                REG_SPEED_NSC: sns_reg       <= cfg_wdata[SNS_W-1:0];
                REG_TURN_NSC:  tns_reg       <= cfg_wdata[TNS_W-1:0];
                default: ;
            endcase
        end
    end

    assign step_time         = step_time_reg;
    assign speed             = speed_reg;
    assign turn_rate         = turn_rate_reg;
    assign speed_noise_scale = sns_reg;
    assign turn_noise_scale  = tns_reg;

endmodule

`default_nettype wire

// File: rtl/upi_cordic.sv
`default_nettype none

module upi_cordic import upi_pkg::*; #(
    parameter int SINCOS_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire logic                           run,
    input  wire logic                           fin,
    input  wire logic [ANG_W-1:0]               angle,
    output logic signed [SINCOS_BITS-1:0]       cos_out,
    output logic signed [SINCOS_BITS-1:0]       sin_out,
    output logic                                last
);

    localparam int CW = CORDIC_FRAC + 4;
    localparam int SH = CORDIC_FRAC - (SINCOS_BITS - 1);
    localparam logic signed [CW-1:0] RND   = CW'(64'sd1 <<< (SH - 1));
    localparam logic signed [CW-1:0] S_MAX = CW'((64'sd1 <<< (SINCOS_BITS - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] S_MIN = -S_MAX - CW'(64'sd1);

    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [CW-1:0] z_reg, z_next;
    logic [1:0]           quad_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic signed [SINCOS_BITS-1:0] cos_reg, sin_reg;

    logic signed [CW-1:0] dx, dy, at;
    logic signed [CW-1:0] xr, yr, xs, ys, cr, sr, cs, ss;

    // One micro-rotation per cycle while run is high
    always_comb begin
        dx = x_reg >>> iter_reg;
        dy = y_reg >>> iter_reg;
        at = $signed({4'b0, atan_turn(iter_reg)});
        if (!z_reg[CW-1]) begin
            x_next = x_reg - dy;
            y_next = y_reg + dx;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + dy;
            y_next = y_reg - dx;
            z_next = z_reg + at;
        end
    end

    // Round half up, saturate, then fold in the quadrant
    always_comb begin
        xr = (x_reg + RND) >>> SH;
        yr = (y_reg + RND) >>> SH;
        xs = (xr > S_MAX) ? S_MAX : ((xr < S_MIN) ? S_MIN : xr);
        ys = (yr > S_MAX) ? S_MAX : ((yr < S_MIN) ? S_MIN : yr);
        unique case (quad_reg)
            2'd0: begin cr = xs;  sr = ys;  end
            2'd1: begin cr = -ys; sr = xs;  end
            2'd2: begin cr = -xs; sr = -ys; end
            default: begin cr = ys; sr = -xs; end
        endcase
        cs = (cr > S_MAX) ? S_MAX : cr;
        ss = (sr > S_MAX) ? S_MAX : sr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= '0;
        end else if (load) begin
            iter_reg <= '0;
        end else if (run && !last) begin
            iter_reg <= iter_reg + ITER_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg    <= $signed({4'b0, CORDIC_GAIN_INV});
            y_reg    <= '0;
            z_reg    <= $signed({4'b0, angle[CORDIC_FRAC-1:0]});
            quad_reg <= angle[ANG_W-1:ANG_W-2];
        end else if (run) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (fin) begin
            cos_reg <= cs[SINCOS_BITS-1:0];
            sin_reg <= ss[SINCOS_BITS-1:0];
        end
    end

    assign last    = (iter_reg == ITER_W'(CORDIC_ITERS - 1));
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

`default_nettype wire

// File: rtl/upi_dp.sv
`default_nettype none

module upi_dp import upi_pkg::*; #(
    parameter int SINCOS_BITS   = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ctrl_cmd_t                    cmd,
    output ctrl_status_t                      status,
    input  wire logic signed [NOISE_W-1:0]    speed_noise,
    input  wire logic signed [NOISE_W-1:0]    turn_noise,
    input  wire logic [ST_W-1:0]              step_time,
    input  wire logic signed [SPEED_W-1:0]    speed,
    input  wire logic signed [TURN_W-1:0]     turn_rate,
    input  wire logic [SNS_W-1:0]             speed_noise_scale,
    input  wire logic [TNS_W-1:0]             turn_noise_scale,
    output logic signed [OUT_POS_W-1:0]       true_x,
    output logic signed [OUT_POS_W-1:0]       true_y,
    output logic signed [HEAD_W-1:0]          true_heading,
    output logic signed [OUT_POS_W-1:0]       noisy_x,
    output logic signed [OUT_POS_W-1:0]       noisy_y,
    output logic signed [HEAD_W-1:0]          noisy_heading
);

    localparam int VN_W    = SPEED_W + 1;
    localparam int WN_W    = TURN_W + 1;
    localparam int D_W     = SPEED_W + 1;
    localparam int DX_W    = D_W + 1;
    localparam int MUL_A_W = WN_W;
    localparam int BW      = (SINCOS_BITS > ST_W + 1) ? SINCOS_BITS : ST_W + 1;
    localparam int PW      = MUL_A_W + BW;
    localparam int SUMW    = ((POSITION_BITS > DX_W) ? POSITION_BITS : DX_W) + 1;
    localparam int OW      = (POSITION_BITS > OUT_POS_W) ? POSITION_BITS : OUT_POS_W;

    localparam logic signed [SUMW-1:0] P_MAX = SUMW'((64'sd1 <<< (POSITION_BITS - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] P_MIN = -P_MAX - SUMW'(64'sd1);
    localparam logic signed [OW-1:0]   O_MAX = OW'(64'sd2147483647);
    localparam logic signed [OW-1:0]   O_MIN = -O_MAX - OW'(64'sd1);

    logic signed [NOISE_W-1:0]       sn_reg, tn_reg;
    logic signed [VN_W-1:0]          vn_reg;
    logic signed [WN_W-1:0]          wn_reg;
    logic signed [D_W-1:0]           d_reg;
    logic signed [PW-1:0]            prod_reg;
    logic signed [POSITION_BITS-1:0] px_reg [2];
    logic signed [POSITION_BITS-1:0] py_reg [2];
    logic [ANG_W-1:0]                ang_reg [2];

    logic signed [OUT_POS_W-1:0]     tx_reg, ty_reg, nx_reg, ny_reg;
    logic signed [HEAD_W-1:0]        th_reg, nh_reg;

    logic signed [MUL_A_W-1:0]       mul_a;
    logic signed [BW-1:0]            mul_b;
    logic signed [SINCOS_BITS-1:0]   cos_w, sin_w;

    logic signed [PW-1:0]            p15, p16, pc;
    logic signed [DX_W-1:0]          dpos;
    logic signed [SUMW-1:0]          psum, psat;

    function automatic logic signed [OUT_POS_W-1:0] sat_out(
        input logic signed [POSITION_BITS-1:0] v
    );
        logic signed [OW-1:0] e;
        e = OW'(v);
        if (e > O_MAX) begin
            e = O_MAX;
        end else if (e < O_MIN) begin
            e = O_MIN;
        end
        return OUT_POS_W'(e);
    endfunction

    upi_cordic #(
        .SINCOS_BITS (SINCOS_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (cmd.cordic_load),
        .run     (cmd.cordic_run),
        .fin     (cmd.cordic_fin),
        .angle   (ang_reg[cmd.pose]),
        .cos_out (cos_w),
        .sin_out (sin_w),
        .last    (status.cordic_last)
    );

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul)
            MUL_NONE: ;
            MUL_SN: begin
                mul_a = MUL_A_W'($signed({1'b0, speed_noise_scale}));
                mul_b = BW'(sn_reg);
            end
            MUL_TN: begin
                mul_a = MUL_A_W'($signed({1'b0, turn_noise_scale}));
                mul_b = BW'(tn_reg);
            end
            MUL_V: begin
                mul_a = (cmd.pose == POSE_NOISY) ? MUL_A_W'(vn_reg) : MUL_A_W'(speed);
                mul_b = BW'($signed({1'b0, step_time}));
            end
            MUL_W: begin
                mul_a = (cmd.pose == POSE_NOISY) ? MUL_A_W'(wn_reg) : MUL_A_W'(turn_rate);
                mul_b = BW'($signed({1'b0, step_time}));
            end
            MUL_C: begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = BW'(cos_w);
            end
            MUL_S: begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = BW'(sin_w);
            end
            default: ;
        endcase
    end

    // Product shifts and position saturation
    always_comb begin
        p15  = prod_reg >>> 15;
        p16  = prod_reg >>> 16;
        pc   = prod_reg >>> (SINCOS_BITS - 1);
        dpos = DX_W'(pc);
        if (cmd.wb == WB_Y) begin
            psum = SUMW'(py_reg[cmd.pose]) + SUMW'(dpos);
        end else begin
            psum = SUMW'(px_reg[cmd.pose]) + SUMW'(dpos);
        end
        psat = (psum > P_MAX) ? P_MAX : ((psum < P_MIN) ? P_MIN : psum);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.in_load) begin
            sn_reg <= speed_noise;
            tn_reg <= turn_noise;
        end
        if (cmd.wb == WB_VN) begin
            vn_reg <= VN_W'(speed) + VN_W'(p15);
        end
        if (cmd.wb == WB_WN) begin
            wn_reg <= WN_W'(turn_rate) + WN_W'(p15);
        end
        if (cmd.wb == WB_D) begin
            d_reg <= D_W'(p16);
        end
        if (cmd.out_load) begin
            tx_reg <= sat_out(px_reg[POSE_TRUE]);
            ty_reg <= sat_out(py_reg[POSE_TRUE]);
            th_reg <= $signed(ang_reg[POSE_TRUE][ANG_W-1:ANG_W-HEAD_W]);
            nx_reg <= sat_out(px_reg[POSE_NOISY]);
            ny_reg <= sat_out(py_reg[POSE_NOISY]);
            nh_reg <= $signed(ang_reg[POSE_NOISY][ANG_W-1:ANG_W-HEAD_W]);
        end
    end

    // Pose state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                px_reg[i]  <= '0;
                py_reg[i]  <= '0;
                ang_reg[i] <= '0;
            end
        end else begin
            unique case (cmd.wb)
                WB_ANG:  ang_reg[cmd.pose] <= ang_reg[cmd.pose] + ANG_W'(p16);
                WB_X:    px_reg[cmd.pose]  <= POSITION_BITS'(psat);
                WB_Y:    py_reg[cmd.pose]  <= POSITION_BITS'(psat);
                default: ;
            endcase
        end
    end

    assign true_x        = tx_reg;
    assign true_y        = ty_reg;
    assign true_heading  = th_reg;
    assign noisy_x       = nx_reg;
    assign noisy_y       = ny_reg;
    assign noisy_heading = nh_reg;

endmodule

`default_nettype wire

// File: rtl/upi_ctrl.sv
`default_nettype none

module upi_ctrl import upi_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire ctrl_status_t  status,
    output ctrl_cmd_t          cmd
);

    fsm_state_t state_reg, state_next;
    pose_t      pose_reg, pose_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pose_reg     <= POSE_TRUE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pose_reg     <= pose_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        pose_next     = pose_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        cmd             = '0;
        cmd.mul         = MUL_NONE;
        cmd.wb          = WB_NONE;
        cmd.pose        = pose_reg;
        s_tready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_NS;
                end
            end
            ST_NS: begin
                cmd.mul    = MUL_SN;
                state_next = ST_NT;
            end
            ST_NT: begin
                cmd.wb     = WB_VN;
                cmd.mul    = MUL_TN;
                state_next = ST_NW;
            end
            ST_NW: begin
                cmd.wb     = WB_WN;
                state_next = ST_CLOAD;
            end
            ST_CLOAD: begin
                cmd.cordic_load = 1'b1;
                state_next      = ST_CROT;
            end
            ST_CROT: begin
                cmd.cordic_run = 1'b1;
                if (status.cordic_last) begin
                    state_next = ST_CFIN;
                end
            end
            ST_CFIN: begin
                cmd.cordic_fin = 1'b1;
                cmd.mul        = MUL_V;
                state_next     = ST_MD;
            end
            ST_MD: begin
                cmd.wb     = WB_D;
                cmd.mul    = MUL_W;
                state_next = ST_MX;
            end
            ST_MX: begin
                cmd.wb     = WB_ANG;
                cmd.mul    = MUL_C;
                state_next = ST_MY;
            end
            ST_MY: begin
                cmd.wb     = WB_X;
                cmd.mul    = MUL_S;
                state_next = ST_MEND;
            end
            ST_MEND: begin
                cmd.wb = WB_Y;
                if (pose_reg == POSE_TRUE) begin
                    pose_next  = POSE_NOISY;
                    state_next = ST_CLOAD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    pose_next     = POSE_TRUE;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_NS))
        else $error("accepted item did not start the sequence");

    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid_reg)
        else $error("result loaded without raising valid");

    a_cordic_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CROT && status.cordic_last) |=> (state_reg == ST_CFIN))
        else $error("rotation did not finish on its last step");

    a_idle_pose: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (pose_reg == POSE_TRUE))
        else $error("idle with noisy pose selected");

endmodule

`default_nettype wire

// File: rtl/unicycle_pose_integrator.sv
// Unicycle pose integrator: dead-reckoning odometry for a true and a noisy pose.
//
// Input channel (s_): one item per tick carries two uniform noise samples.
// Result channel (m_): one item per accepted input, holding both poses after
// the tick (positions saturated to 32 bits, headings as the upper angle bits).
// Configuration: write cfg_wdata into register cfg_index while cfg_we is high;
// only do so while no item is in flight.
//
// The block takes one item at a time: s_tready is high only while idle, and a new
// item is not accepted until the last result has been loaded into the output
// register. The work runs on one shared 30-step CORDIC unit, run once per pose,
// and one shared multiplier that evaluates the ten products of a tick in turn.
//
// Reset (aresetn low, synchronous) zeroes both poses, reloads the register
// defaults and drops m_tvalid. When the receiver stalls, the finished item
// waits in the output register; the block returns to accepting and computing
// the next item and holds that one until the output register frees up.
`default_nettype none

module unicycle_pose_integrator import upi_pkg::*; #(
    parameter int SINCOS_BITS   = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // speed_noise [15:0], turn_noise [31:16]
    input  wire logic [31:0]            s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // true_x [31:0], true_y [63:32], true_heading [79:64],
    // noisy_x [111:80], noisy_y [143:112], noisy_heading [159:144]
    output logic [159:0]                m_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [ST_W-1:0]           step_time;
    logic signed [SPEED_W-1:0] speed;
    logic signed [TURN_W-1:0]  turn_rate;
    logic [SNS_W-1:0]          speed_noise_scale;
    logic [TNS_W-1:0]          turn_noise_scale;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    logic signed [OUT_POS_W-1:0] true_x, true_y, noisy_x, noisy_y;
    logic signed [HEAD_W-1:0]    true_heading, noisy_heading;

    // Configuration registers
    upi_cfg u_cfg (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .step_time         (step_time),
        .speed             (speed),
        .turn_rate         (turn_rate),
        .speed_noise_scale (speed_noise_scale),
        .turn_noise_scale  (turn_noise_scale)
    );

    // Sequencer: owns both handshakes and steps the datapath
    upi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Pose state, shared multiplier, CORDIC and output register
    upi_dp #(
        .SINCOS_BITS   (SINCOS_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .speed_noise       ($signed(s_tdata[15:0])),
        .turn_noise        ($signed(s_tdata[31:16])),
        .step_time         (step_time),
        .speed             (speed),
        .turn_rate         (turn_rate),
        .speed_noise_scale (speed_noise_scale),
        .turn_noise_scale  (turn_noise_scale),
        .true_x            (true_x),
        .true_y            (true_y),
        .true_heading      (true_heading),
        .noisy_x           (noisy_x),
        .noisy_y           (noisy_y),
        .noisy_heading     (noisy_heading)
    );

    assign m_tdata = {noisy_heading, noisy_y, noisy_x, true_heading, true_y, true_x};

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import upi_pkg::*;

    // Geometry of the block under test, kept at its defaults
    localparam int SINCOS_BITS   = 16;
    localparam int POSITION_BITS = 32;

    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 8;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     TAIL_CYCLES   = 100;
    localparam int     HOLD_OFF_LEN  = 600;
    localparam int     RANDOM_PHASES = 10;
    localparam int     RANDOM_ITEMS  = 72;
    localparam int     REPORT_LIMIT  = 10;

    localparam logic [NOISE_W-1:0] NOISE_MIN = 16'h8000;
    localparam logic [NOISE_W-1:0] NOISE_MAX = 16'h7FFF;

    // Register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_FIRST = REG_TURN_NSC + 1;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LAST  = '1;

    // CORDIC for the expected sine and cosine
    localparam int     CORDIC_STEPS   = 30;
    localparam int     CORDIC_FRAC_B  = 30;
    localparam longint CORDIC_START_X = 64'd652032874;

    // Arctangent of 2^-i, in 2^-32 turn
    longint cordic_angle [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef struct {
        logic [OUT_POS_W-1:0] true_x;
        logic [OUT_POS_W-1:0] true_y;
        logic [HEAD_W-1:0]    true_heading;
        logic [OUT_POS_W-1:0] noisy_x;
        logic [OUT_POS_W-1:0] noisy_y;
        logic [HEAD_W-1:0]    noisy_heading;
    } pose_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [159:0]          m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Expected pose pairs, oldest first
    pose_result_t expected_poses [$];
    pose_result_t got_expect;

    // Predicted register contents
    longint cf_step;
    longint cf_speed;
    longint cf_turn;
    longint cf_sns;
    longint cf_tns;

    // Predicted poses
    longint      tp_x, tp_y, np_x, np_y;
    logic [31:0] tp_ang, np_ang;

    int fail_count    = 0;
    int cycle_count   = 0;
    int hold_off_left = 0;
    int rx_stall_left = 0;
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;

    unicycle_pose_integrator #(
        .SINCOS_BITS   (SINCOS_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #(CLK_HALF);
        aclk = 1'b1;
        #(CLK_HALF);
    end

    // ------------------------------------------------------------------
    // Pose prediction
    // ------------------------------------------------------------------

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Rotate the unit vector into the first quadrant, then fold back by the top bits.
    task automatic sine_cosine(input logic [31:0] ang, output longint c, output longint s);
        longint x, y, z, nx, xr, yr;
        int     sh;
        sh = CORDIC_FRAC_B - (SINCOS_BITS - 1);
        x  = CORDIC_START_X;
        y  = 0;
        z  = longint'(ang[29:0]);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - cordic_angle[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + cordic_angle[i];
            end
            x = nx;
        end
        xr = clamp((x + (longint'(1) <<< (sh - 1))) >>> sh, SINCOS_BITS);
        yr = clamp((y + (longint'(1) <<< (sh - 1))) >>> sh, SINCOS_BITS);
        case (ang[31:30])
            2'b00: begin
                c = xr;
                s = yr;
            end
            2'b01: begin
                c = -yr;
                s = xr;
            end
            2'b10: begin
                c = -xr;
                s = -yr;
            end
            default: begin
                c = yr;
                s = -xr;
            end
        endcase
        c = clamp(c, SINCOS_BITS);
        s = clamp(s, SINCOS_BITS);
    endtask

    // Move along the old heading, then turn.
    task automatic advance_pose(inout longint px, inout longint py, inout logic [31:0] ang,
                                input longint v, input longint w);
        longint c, s, d;
        sine_cosine(ang, c, s);
        d   = (v * cf_step) >>> 16;
        px  = clamp(px + ((d * c) >>> (SINCOS_BITS - 1)), POSITION_BITS);
        py  = clamp(py + ((d * s) >>> (SINCOS_BITS - 1)), POSITION_BITS);
        d   = (w * cf_step) >>> 16;
        ang = ang + d[31:0];
    endtask

    task automatic predict_tick(input logic [NOISE_W-1:0] speed_noise,
                                input logic [NOISE_W-1:0] turn_noise);
        longint       v, w;
        pose_result_t r;
        v = cf_speed + ((longint'($signed(speed_noise)) * cf_sns) >>> 15);
        w = cf_turn + ((longint'($signed(turn_noise)) * cf_tns) >>> 15);
        advance_pose(tp_x, tp_y, tp_ang, cf_speed, cf_turn);
        advance_pose(np_x, np_y, np_ang, v, w);
        r.true_x        = clamp(tp_x, OUT_POS_W);
        r.true_y        = clamp(tp_y, OUT_POS_W);
        r.true_heading  = tp_ang[31:16];
        r.noisy_x       = clamp(np_x, OUT_POS_W);
        r.noisy_y       = clamp(np_y, OUT_POS_W);
        r.noisy_heading = np_ang[31:16];
        expected_poses.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [NOISE_W-1:0] random_noise();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return NOISE_MIN;
        if (pick == 1) return NOISE_MAX;
        return NOISE_W'($urandom());
    endfunction

    // Pick a register value: an extreme, raw bits, or an in-range value of random size.
    function automatic logic [31:0] pick_setting(input logic [31:0] low, input logic [31:0] high,
                                                 input int width, input bit is_signed);
        logic [31:0] raw;
        int          sh;
        raw = $urandom();
        sh  = $urandom_range(0, 6);
        case ($urandom_range(0, 7))
            0: return low;
            1: return high;
            2: return raw;
            default: begin
                if (is_signed)
                    return 32'($signed(raw << (32 - width)) >>> ((32 - width) + sh));
                return (raw >> (32 - width)) >> sh;
            end
        endcase
    endfunction

    // Write one register and mirror it in the prediction. Call at a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_STEP_TIME: cf_step  = longint'(val[ST_W-1:0]);
            REG_SPEED:     cf_speed = longint'($signed(val[SPEED_W-1:0]));
            REG_TURN_RATE: cf_turn  = longint'($signed(val[TURN_W-1:0]));
            REG_SPEED_NSC: cf_sns   = longint'(val[SNS_W-1:0]);
            REG_TURN_NSC:  cf_tns   = longint'(val[TNS_W-1:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one item, wait for the handshake, predict. Starts and ends at a falling edge;
    // s_tvalid stays high so back-to-back items need no toggle.
    task automatic send_noise(input logic [NOISE_W-1:0] speed_noise,
                              input logic [NOISE_W-1:0] turn_noise);
        int gap;
        gap = 0;
        if (!sender_steady && $urandom_range(0, 2) == 0)
            gap = random_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {turn_noise, speed_noise};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tick(speed_noise, turn_noise);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every predicted pose pair has come out.
    task automatic wait_for_poses();
        s_tvalid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: hold-off first, then any running stall, then random readiness.
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            m_tready      <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else if (rx_stall_left > 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (receiver_steady || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready      <= 1'b0;
            rx_stall_left <= random_gap() - 1;
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_poses.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: result item with no prediction pending: %h",
                             $realtime, m_tdata);
            end else begin
                got_expect = expected_poses.pop_front();
                check_field("true_x",        got_expect.true_x,        m_tdata[31:0]);
                check_field("true_y",        got_expect.true_y,        m_tdata[63:32]);
                check_field("true_heading",  32'(got_expect.true_heading),  32'(m_tdata[79:64]));
                check_field("noisy_x",       got_expect.noisy_x,       m_tdata[111:80]);
                check_field("noisy_y",       got_expect.noisy_y,       m_tdata[143:112]);
                check_field("noisy_heading", 32'(got_expect.noisy_heading),
                            32'(m_tdata[159:144]));
            end
        end
    end

    // Watchdog: end the run with a fail once the cycle limit is reached.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("unicycle_pose_integrator regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Noise extremes under the reset settings; every input bit toggles.
    task automatic test_field_extremes();
        send_noise(16'h0000, 16'h0000);
        send_noise(NOISE_MAX, NOISE_MAX);
        send_noise(NOISE_MIN, NOISE_MIN);
        send_noise(NOISE_MAX, NOISE_MIN);
        send_noise(NOISE_MIN, NOISE_MAX);
        send_noise(16'hFFFF, 16'h0001);
        send_noise(16'h0001, 16'hFFFF);
    endtask

    // Heading is still close to zero here, so x runs into both rails.
    task automatic test_position_saturation();
        wait_for_poses();
        write_reg(REG_STEP_TIME, 32'd65535);
        write_reg(REG_SPEED, 32'h007F_FFFF);
        write_reg(REG_TURN_RATE, 32'd0);
        write_reg(REG_SPEED_NSC, 32'h007F_FFFF);
        write_reg(REG_TURN_NSC, 32'd0);
        // Drive both poses to the top rail, the true one at full speed
        repeat (290) send_noise(NOISE_W'($urandom_range(16384, 32767)), random_noise());
        wait_for_poses();
        // Reverse at the most negative speed; the noisy pose reaches the bottom rail
        write_reg(REG_SPEED, 32'h0080_0000);
        repeat (280) send_noise(NOISE_MIN, random_noise());
    endtask

    // All registers at their top values, then at their bottom values, but step time at 1.
    // Full-scale turn rates wrap the headings every tick or two.
    task automatic test_config_extremes();
        wait_for_poses();
        write_reg(REG_STEP_TIME, 32'd65535);
        write_reg(REG_SPEED, 32'h007F_FFFF);
        write_reg(REG_TURN_RATE, 32'h7FFF_FFFF);
        write_reg(REG_SPEED_NSC, 32'h007F_FFFF);
        write_reg(REG_TURN_NSC, 32'h7FFF_FFFF);
        send_noise(NOISE_MAX, NOISE_MAX);
        send_noise(NOISE_MIN, NOISE_MIN);
        send_noise(NOISE_MAX, NOISE_MIN);
        send_noise(random_noise(), random_noise());
        wait_for_poses();
        write_reg(REG_STEP_TIME, 32'd1);
        write_reg(REG_SPEED, 32'hFF80_0000);
        write_reg(REG_TURN_RATE, 32'h8000_0000);
        write_reg(REG_SPEED_NSC, 32'd0);
        write_reg(REG_TURN_NSC, 32'd0);
        send_noise(NOISE_MAX, NOISE_MAX);
        send_noise(NOISE_MIN, NOISE_MIN);
        send_noise(random_noise(), random_noise());
        send_noise(random_noise(), random_noise());
    endtask

    // Zero tick length (high bits set, low half clear) must freeze both poses.
    task automatic test_step_freeze();
        wait_for_poses();
        write_reg(REG_STEP_TIME, 32'hFFFF_0000);
        write_reg(REG_SPEED, 32'h0001_0000);
        write_reg(REG_TURN_RATE, 32'h0400_0000);
        write_reg(REG_SPEED_NSC, 32'hFF80_4000);
        write_reg(REG_TURN_NSC, 32'hF000_1000);
        repeat (3) send_noise(random_noise(), random_noise());
    endtask

    // Writes to indexes with no register behind them change nothing.
    task automatic test_spare_index();
        wait_for_poses();
        write_reg(REG_STEP_TIME, 32'd3277);
        for (int k = IDX_SPARE_FIRST; k <= IDX_SPARE_LAST; k++)
            write_reg(CFG_IDX_W'(k), $urandom());
        repeat (2) send_noise(random_noise(), random_noise());
    endtask

    // Hold the receiver off long enough that the block fills and stalls its input,
    // while the sender keeps offering items back to back.
    task automatic test_backpressure();
        wait_for_poses();
        sender_steady = 1'b1;
        hold_off_left <= HOLD_OFF_LEN;
        repeat (12) send_noise(random_noise(), random_noise());
        sender_steady = 1'b0;
        wait_for_poses();
    endtask

    // Phases of random settings, each followed by random noise items.
    task automatic test_random();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_poses();
            write_reg(REG_STEP_TIME, pick_setting(32'd1, 32'd65535, ST_W, 1'b0));
            write_reg(REG_SPEED, pick_setting(32'hFF80_0000, 32'h007F_FFFF, SPEED_W, 1'b1));
            write_reg(REG_TURN_RATE, pick_setting(32'h8000_0000, 32'h7FFF_FFFF, TURN_W, 1'b1));
            write_reg(REG_SPEED_NSC, pick_setting(32'd0, 32'h007F_FFFF, SNS_W, 1'b0));
            write_reg(REG_TURN_NSC, pick_setting(32'd0, 32'h7FFF_FFFF, TNS_W, 1'b0));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(IDX_SPARE_FIRST, IDX_SPARE_LAST)),
                          $urandom());
            // First phase runs with no idling on either side
            sender_steady   = (phase == 0);
            receiver_steady = (phase == 0) || ($urandom_range(0, 5) == 0);
            repeat (RANDOM_ITEMS) send_noise(random_noise(), random_noise());
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    initial begin
        // Reset state of the prediction
        cf_step  = longint'(STEP_TIME_RST);
        cf_speed = longint'(SPEED_RST);
        cf_turn  = longint'(TURN_RATE_RST);
        cf_sns   = longint'(SNS_RST);
        cf_tns   = longint'(TNS_RST);
        tp_x = 0; tp_y = 0; np_x = 0; np_y = 0;
        tp_ang = '0;
        np_ang = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_field_extremes();
        test_position_saturation();
        test_config_extremes();
        test_step_freeze();
        test_spare_index();
        test_backpressure();
        test_random();

        // Drain, then watch for stray results
        wait_for_poses();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_poses.size() == 0) begin
            $display("unicycle_pose_integrator regression: pass");
        end else begin
            $display("unicycle_pose_integrator regression: fail");
        end
        $finish;
    end

endmodule
